/* sv/sc2a_pkg.sv */
`timescale 1ns / 1ps

package sc2a_pkg;

    // Character queue geometry
    localparam int FIFO_DEPTH = 256;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);

    // Operation codes
    localparam logic [1:0] OP_SCAN = 2'd0;
    localparam logic [1:0] OP_POP  = 2'd1;
    localparam logic [1:0] OP_PEEK = 2'd2;

    // Set 1 make codes with special handling
    localparam logic [6:0] SC_LSHIFT = 7'h2A;
    localparam logic [6:0] SC_RSHIFT = 7'h36;
    localparam logic [7:0] SC_CAPS   = 8'h3A;
    localparam logic [7:0] SC_CTRL   = 8'h1D;
    localparam logic [7:0] SC_ALT    = 8'h38;

    // ASCII helpers
    localparam logic [6:0] CH_LOWER_A  = 7'h61;
    localparam logic [6:0] CH_LOWER_Z  = 7'h7A;
    localparam logic [6:0] CASE_OFFSET = 7'd32;

    // Controller to datapath commands
    typedef struct packed {
        logic load;     // capture an incoming item
        logic exec;     // carry out the captured item and load the result
    } sc2a_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic slot_free;    // result register can take a new item
    } sc2a_stat_t;

    // Ring pointer increment with wrap
    function automatic logic [PTR_W-1:0] sc2a_advance(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] n;
        if (p == PTR_W'(FIFO_DEPTH - 1))
            n = '0;
        else
            n = p + 1'b1;
        return n;
    endfunction

endpackage

/* sv/sc2a_ctrl.sv */
`timescale 1ns / 1ps

module sc2a_ctrl
    import sc2a_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cmd_valid,
    output logic       cmd_stall,
    input  sc2a_stat_t stat,
    output sc2a_cmd_t  cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic state_reg;
    logic state_next;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                    state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                if (stat.slot_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Commands
    assign cmd_stall = (state_reg != ST_IDLE);
    assign cmd.load  = (state_reg == ST_IDLE) && cmd_valid;
    assign cmd.exec  = (state_reg == ST_EXEC) && stat.slot_free;

endmodule

/* sv/sc2a_datapath.sv */
`timescale 1ns / 1ps

module sc2a_datapath
    import sc2a_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  sc2a_cmd_t  cmd,
    output sc2a_stat_t stat,
    input  logic [1:0] op,
    input  logic [7:0] scancode,
    output logic       rsp_valid,
    input  logic       rsp_stall,
    output logic [6:0] out_char,
    output logic       char_valid,
    output logic       fifo_nonempty,
    output logic       dropped
);

    // Captured item
    logic [1:0]       op_reg;
    logic [7:0]       sc_reg;

    // Keyboard and queue state
    logic             shift_reg;
    logic             shift_next;
    logic             caps_reg;
    logic             caps_next;
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [6:0]       char_mem [FIFO_DEPTH];
    logic [6:0]       rd_data_reg;

    // Result register
    logic             rsp_valid_reg;
    logic             rsp_valid_next;
    logic [6:0]       out_char_reg;
    logic             char_valid_reg;
    logic             nonempty_reg;
    logic             dropped_reg;

    // Step results
    logic [6:0]       key;
    logic [6:0]       plain_ch;
    logic [6:0]       upper_ch;
    logic [6:0]       dec_char;
    logic             is_shift_key;
    logic             full;
    logic             push;
    logic             lost;
    logic [6:0]       res_char;
    logic             res_valid;

    // Unshifted set 1 map
    function automatic logic [6:0] sc2a_plain(input logic [6:0] k);
        logic [6:0] c;
        unique case (k)
            7'h02: c = 7'h31;  7'h03: c = 7'h32;  7'h04: c = 7'h33;  7'h05: c = 7'h34;
            7'h06: c = 7'h35;  7'h07: c = 7'h36;  7'h08: c = 7'h37;  7'h09: c = 7'h38;
            7'h0A: c = 7'h39;  7'h0B: c = 7'h30;  7'h0C: c = 7'h2D;  7'h0D: c = 7'h3D;
            7'h0E: c = 7'h08;  7'h0F: c = 7'h09;
            7'h10: c = 7'h71;  7'h11: c = 7'h77;  7'h12: c = 7'h65;  7'h13: c = 7'h72;
            7'h14: c = 7'h74;  7'h15: c = 7'h79;  7'h16: c = 7'h75;  7'h17: c = 7'h69;
            7'h18: c = 7'h6F;  7'h19: c = 7'h70;  7'h1A: c = 7'h5B;  7'h1B: c = 7'h5D;
            7'h1C: c = 7'h0A;
            7'h1E: c = 7'h61;  7'h1F: c = 7'h73;  7'h20: c = 7'h64;  7'h21: c = 7'h66;
            7'h22: c = 7'h67;  7'h23: c = 7'h68;  7'h24: c = 7'h6A;  7'h25: c = 7'h6B;
            7'h26: c = 7'h6C;  7'h27: c = 7'h3B;  7'h28: c = 7'h27;  7'h29: c = 7'h60;
            7'h2B: c = 7'h5C;  7'h2C: c = 7'h7A;  7'h2D: c = 7'h78;  7'h2E: c = 7'h63;
            7'h2F: c = 7'h76;  7'h30: c = 7'h62;  7'h31: c = 7'h6E;  7'h32: c = 7'h6D;
            7'h33: c = 7'h2C;  7'h34: c = 7'h2E;  7'h35: c = 7'h2F;
            7'h37: c = 7'h2A;  7'h39: c = 7'h20;
            7'h47: c = 7'h37;  7'h48: c = 7'h38;  7'h49: c = 7'h39;  7'h4A: c = 7'h2D;
            7'h4B: c = 7'h34;  7'h4C: c = 7'h35;  7'h4D: c = 7'h36;  7'h4E: c = 7'h2B;
            7'h4F: c = 7'h31;  7'h50: c = 7'h32;  7'h51: c = 7'h33;  7'h52: c = 7'h30;
            7'h53: c = 7'h2E;
            default: c = 7'h00;
        endcase
        return c;
    endfunction

    // Shifted set 1 map
    function automatic logic [6:0] sc2a_upper(input logic [6:0] k);
        logic [6:0] c;
        unique case (k)
            7'h02: c = 7'h21;  7'h03: c = 7'h40;  7'h04: c = 7'h23;  7'h05: c = 7'h24;
            7'h06: c = 7'h25;  7'h07: c = 7'h5E;  7'h08: c = 7'h26;  7'h09: c = 7'h2A;
            7'h0A: c = 7'h28;  7'h0B: c = 7'h29;  7'h0C: c = 7'h5F;  7'h0D: c = 7'h2B;
            7'h0E: c = 7'h08;  7'h0F: c = 7'h09;
            7'h10: c = 7'h51;  7'h11: c = 7'h57;  7'h12: c = 7'h45;  7'h13: c = 7'h52;
            7'h14: c = 7'h54;  7'h15: c = 7'h59;  7'h16: c = 7'h55;  7'h17: c = 7'h49;
            7'h18: c = 7'h4F;  7'h19: c = 7'h50;  7'h1A: c = 7'h7B;  7'h1B: c = 7'h7D;
            7'h1C: c = 7'h0A;
            7'h1E: c = 7'h41;  7'h1F: c = 7'h53;  7'h20: c = 7'h44;  7'h21: c = 7'h46;
            7'h22: c = 7'h47;  7'h23: c = 7'h48;  7'h24: c = 7'h4A;  7'h25: c = 7'h4B;
            7'h26: c = 7'h4C;  7'h27: c = 7'h3A;  7'h28: c = 7'h22;  7'h29: c = 7'h7E;
            7'h2B: c = 7'h7C;  7'h2C: c = 7'h5A;  7'h2D: c = 7'h58;  7'h2E: c = 7'h43;
            7'h2F: c = 7'h56;  7'h30: c = 7'h42;  7'h31: c = 7'h4E;  7'h32: c = 7'h4D;
            7'h33: c = 7'h3C;  7'h34: c = 7'h3E;  7'h35: c = 7'h3F;
            7'h37: c = 7'h2A;  7'h39: c = 7'h20;
            7'h47: c = 7'h37;  7'h48: c = 7'h38;  7'h49: c = 7'h39;  7'h4A: c = 7'h2D;
            7'h4B: c = 7'h34;  7'h4C: c = 7'h35;  7'h4D: c = 7'h36;  7'h4E: c = 7'h2B;
            7'h4F: c = 7'h31;  7'h50: c = 7'h32;  7'h51: c = 7'h33;  7'h52: c = 7'h30;
            7'h53: c = 7'h2E;
            default: c = 7'h00;
        endcase
        return c;
    endfunction

    // Item capture
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg <= op;
            sc_reg <= scancode;
        end
    end

    // Key decode
    assign key          = sc_reg[6:0];
    assign is_shift_key = (key == SC_LSHIFT) || (key == SC_RSHIFT);
    assign plain_ch     = sc2a_plain(key);
    assign upper_ch     = sc2a_upper(key);

    always_comb
    begin
        if (shift_reg)
            dec_char = upper_ch;
        else if (caps_reg && (plain_ch >= CH_LOWER_A) && (plain_ch <= CH_LOWER_Z))
            dec_char = plain_ch - CASE_OFFSET;
        else
            dec_char = plain_ch;
    end

    assign full = (sc2a_advance(wr_ptr_reg) == rd_ptr_reg);

    // Step evaluation
    always_comb
    begin
        shift_next  = shift_reg;
        caps_next   = caps_reg;
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        push        = 1'b0;
        lost        = 1'b0;
        res_char    = 7'h00;
        res_valid   = 1'b0;
        unique case (op_reg)
            OP_SCAN:
            begin
                if (sc_reg[7])
                begin
                    // release: only shift keys matter
                    if (is_shift_key)
                        shift_next = 1'b0;
                end
                else if (is_shift_key)
                    shift_next = 1'b1;
                else if (sc_reg == SC_CAPS)
                    caps_next = !caps_reg;
                else if ((sc_reg == SC_CTRL) || (sc_reg == SC_ALT))
                    shift_next = shift_reg;
                else if (dec_char != 7'h00)
                begin
                    if (full)
                        lost = 1'b1;
                    else
                    begin
                        push        = 1'b1;
                        wr_ptr_next = sc2a_advance(wr_ptr_reg);
                    end
                end
            end
            OP_POP, OP_PEEK:
            begin
                if (wr_ptr_reg != rd_ptr_reg)
                begin
                    res_char  = rd_data_reg;
                    res_valid = 1'b1;
                    if (op_reg == OP_POP)
                        rd_ptr_next = sc2a_advance(rd_ptr_reg);
                end
            end
            default:
            begin
                res_valid = 1'b0;
            end
        endcase
    end

    // State update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_reg  <= 1'b0;
            caps_reg   <= 1'b0;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end
        else if (cmd.exec)
        begin
            shift_reg  <= shift_next;
            caps_reg   <= caps_next;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    // Character store, registered read at the head of the queue
    always_ff @(posedge clk)
    begin
        if (cmd.exec && push)
            char_mem[wr_ptr_reg] <= dec_char;
        rd_data_reg <= char_mem[rd_ptr_reg];
    end

    // Result register
    assign stat.slot_free = !rsp_valid_reg || !rsp_stall;

    always_comb
    begin
        if (cmd.exec)
            rsp_valid_next = 1'b1;
        else if (!rsp_stall)
            rsp_valid_next = 1'b0;
        else
            rsp_valid_next = rsp_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else
            rsp_valid_reg <= rsp_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            out_char_reg   <= res_char;
            char_valid_reg <= res_valid;
            nonempty_reg   <= (wr_ptr_next != rd_ptr_next);
            dropped_reg    <= lost;
        end
    end

    assign rsp_valid     = rsp_valid_reg;
    assign out_char      = out_char_reg;
    assign char_valid    = char_valid_reg;
    assign fifo_nonempty = nonempty_reg;
    assign dropped       = dropped_reg;

    // Checks
    a_exec_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec |-> stat.slot_free)
        else $error("item executed while result register occupied");

    a_drop_xor_char: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg |-> !(dropped_reg && char_valid_reg))
        else $error("result flags both a drop and a character");

    a_push_moves_wr: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.exec && push) |=> (wr_ptr_reg != $past(wr_ptr_reg)))
        else $error("write pointer did not advance on push");

    a_no_load_in_exec: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec |-> !cmd.load)
        else $error("capture and execute in the same cycle");

endmodule

/* sv/scancode_to_ascii_fifo.sv */
// Channel   Handshake              Item fields
// command   cmd_valid / cmd_stall  op, scancode
// response  rsp_valid / rsp_stall  out_char, char_valid, fifo_nonempty, dropped
//
// An item is captured, then executed against the registered head of the character
// store; one item is in work at a time.
// A new item is taken while a finished result still waits in the response register.
// Execution waits while that register is full and stalled.
// rst_n clears shift, caps lock, both queue pointers and the response valid.
`timescale 1ns / 1ps

module scancode_to_ascii_fifo
    import sc2a_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cmd_valid,
    output logic       cmd_stall,
    input  logic [1:0] op,
    input  logic [7:0] scancode,
    output logic       rsp_valid,
    input  logic       rsp_stall,
    output logic [6:0] out_char,
    output logic       char_valid,
    output logic       fifo_nonempty,
    output logic       dropped
);

    sc2a_cmd_t  cmd;
    sc2a_stat_t stat;

    // Sequencer
    sc2a_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Decode, queue and response
    sc2a_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .op            (op),
        .scancode      (scancode),
        .rsp_valid     (rsp_valid),
        .rsp_stall     (rsp_stall),
        .out_char      (out_char),
        .char_valid    (char_valid),
        .fifo_nonempty (fifo_nonempty),
        .dropped       (dropped)
    );

endmodule
